>>> design/tdf_pkg.sv
// Package for the fhan tracking differentiator: sequencer states, register indexes.
// No dependencies.
package tdf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D1,
    ST_D2,
    ST_A0,
    ST_Y,
    ST_SQ,
    ST_RAD,
    ST_SQRT,
    ST_A2,
    ST_A,
    ST_QM,
    ST_DIV,
    ST_FH,
    ST_NV,
    ST_OUT
  } state_e;

  localparam logic [1:0] REG_SPEED = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

endpackage

>>> design/tdf_sqrt.sv
// Bit-serial integer square root of a double-width unsigned value.
// Uses tdf_pkg for nothing; standalone iterative unit.
module tdf_sqrt #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] rad_i,
  output logic         done_o,
  output logic [W/2-1:0] root_o
);
  localparam int unsigned CW = $clog2(W/2 + 1);

  logic [W-1:0]   rad_q, rad_d;
  logic [W/2+1:0] rem_q, rem_d;
  logic [W/2-1:0] root_q, root_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic [W/2+1:0] trial;
  logic [W/2+1:0] shifted;

  // One result bit a step: restoring two-bit shift form.
  always_comb begin
    shifted = {rem_q[W/2-1:0], rad_q[W-1 -: 2]};
    trial   = {root_q, 2'b01};
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_o  = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(W/2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[W/2-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[W/2-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
endmodule

>>> design/tdf_div.sv
// Restoring divider: double-width dividend over a single-width divisor,
// quotient known to fit in W bits. Standalone iterative unit.
module tdf_div #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*W-1:0] num_i,
  input  logic [W-1:0]   den_i,
  output logic           done_o,
  output logic [W-1:0]   quo_o
);
  localparam int unsigned CW = $clog2(2*W + 1);

  logic [2*W-1:0] num_q, num_d;
  logic [W:0]     rem_q, rem_d;
  logic [W-1:0]   den_q, den_d;
  logic [W-1:0]   quo_q, quo_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic [W:0]     sh;

  always_comb begin
    sh     = {rem_q[W-1:0], num_q[2*W-1]};
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CW'(2*W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[2*W-2:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;
endmodule

>>> design/tracking_differentiator_fhan_unit.sv
// Top level of the fhan tracking differentiator: sequencer, shared multiplier,
// state and configuration registers. Depends on tdf_pkg, tdf_sqrt, tdf_div.
//
// Usage:
//   Request channel (req_valid_i/req_ready_o) carries req_type, target, pos_in
//   and vel_in. One request yields exactly one response on the response
//   channel (rsp_valid_o/rsp_ready_i) with position_out and velocity_out.
//   Configuration writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   set speed_factor (0), filter_step (1) and rate_limit (2); write only while
//   the unit is idle. Other indexes are taken and dropped.
// Sequencing:
//   One request at a time. The serial square root and, when |a| < d, the
//   restoring divider run between the sequencer steps; when |a| >= d no
//   division runs. req_ready_o is high only while the sequencer is idle.
// Reset:
//   Position and velocity clear to zero; registers take 1.0, 1.0 and -1.0.
// Stall:
//   A finished response holds in the output register until taken. Meanwhile
//   the next request is taken and computed, then holds in its last step until
//   the waiting response leaves; the new one replaces it at that same edge.
module tracking_differentiator_fhan_unit
  import tdf_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        req_type_i,
  input  logic signed [31:0] target_i,
  input  logic signed [31:0] pos_in_i,
  input  logic signed [31:0] vel_in_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic signed [31:0] position_out_o,
  output logic signed [31:0] velocity_out_o
);
  localparam int unsigned DW = DATA_WIDTH;
  // headroom for sums and for 32-bit port and register values at any width
  localparam int unsigned WW = ((DW > 32) ? DW : 32) + 3;
  localparam logic signed [WW-1:0] VMAX = WW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [WW-1:0] VMIN = -VMAX - WW'(1);

  // Saturate a wide signed value into the data range.
  function automatic logic signed [DW-1:0] sat_f(input logic signed [WW-1:0] x);
    if (x > VMAX) return VMAX[DW-1:0];
    if (x < VMIN) return VMIN[DW-1:0];
    return x[DW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] ext_f(input logic signed [DW-1:0] x);
    return WW'(x);
  endfunction

  function automatic logic signed [DW-1:0] in_f(input logic [31:0] x);
    logic signed [WW-1:0] w;
    w = WW'(signed'(x));
    return sat_f(w);
  endfunction

  function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  // ---------------------------------------------------------------- config
  logic [30:0] speed_q;
  logic [30:0] step_q;
  logic signed [31:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= 31'd65536;
      step_q  <= 31'd65536;
      limit_q <= -32'sd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPEED: speed_q <= cfg_data_i[30:0];
        REG_STEP:  step_q  <= cfg_data_i[30:0];
        REG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  state_e state_q, state_d;
  logic signed [DW-1:0] pos_q, vel_q;             // tracked state
  logic signed [DW-1:0] x1_q, x2_q, v_q, r_q, h_q;
  logic signed [DW-1:0] d_q, a0_q, y_q, a2_q, a_q, fh_q, nv_q;
  logic                 sup_q;
  logic [2*DW-1:0]      prod_q;                   // registered shared product
  logic signed [DW-1:0] pos_o_q, vel_o_q;
  logic                 rsp_q;

  // Shared multiplier: operands selected by state, magnitude product.
  logic signed [DW-1:0] ma, mb;
  logic [2*DW-1:0]      mp;
  logic                 mneg;
  logic signed [DW-1:0] fmul;   // fixed-point result of prod_q
  logic                 fneg_q;

  always_comb begin
    ma = r_q;
    mb = h_q;
    unique case (state_q)
      ST_D1:   begin ma = r_q; mb = h_q; end
      ST_D2:   begin ma = fmul; mb = h_q; end
      ST_A0:   begin ma = h_q; mb = x2_q; end
      ST_Y:    begin ma = d_q; mb = d_q; end    // d*d for the radicand
      ST_SQ:   begin ma = d_q; mb = y_q; end    // d*|y| for the radicand
      ST_QM:   begin ma = r_q; mb = a_q; end
      default: begin ma = r_q; mb = h_q; end
    endcase
    mneg = ma[DW-1] ^ mb[DW-1];
    mp   = (2*DW)'(mag_f(ma)) * (2*DW)'(mag_f(mb));
  end

  // Scale the registered product back to fixed point with saturation.
  always_comb begin
    logic [2*DW-1:0] q;
    q = prod_q >> FRAC_BITS;
    if (q > (2*DW)'(VMAX[DW-1:0])) fmul = fneg_q ? VMIN[DW-1:0] : VMAX[DW-1:0];
    else fmul = fneg_q ? DW'(-q[DW-1:0]) : q[DW-1:0];
  end

  // Radicand d*(d+8|y|) = d*d + 8*d*|y| fits in 2*DW+4 bits; even sqrt width.
  localparam int unsigned SW = 2 * DW + 4;
  logic [SW-1:0]   rad_q;    // d*d
  logic [SW-1:0]   rad_sum;
  logic            sq_start, sq_done;
  logic [SW/2-1:0] root;
  logic            dv_start, dv_done;
  logic [DW-1:0]   quo;

  assign rad_sum = rad_q + (SW'(prod_q) << 3);

  tdf_sqrt #(.W(SW)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sq_start), .rad_i(rad_sum),
    .done_o(sq_done), .root_o(root)
  );

  tdf_div #(.W(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(dv_start), .num_i(prod_q),
    .den_i(DW'(d_q)), .done_o(dv_done), .quo_o(quo)
  );

  logic [DW-1:0] ay, aa;
  assign ay = mag_f(y_q);
  assign aa = mag_f(a_q);

  logic req_acc, rsp_acc, out_fire;
  assign req_ready_o = (state_q == ST_IDLE);
  assign req_acc     = req_valid_i && req_ready_o;
  assign rsp_acc     = rsp_q && rsp_ready_i;
  // Hand the finished pair to the output register once it is free.
  assign out_fire    = (state_q == ST_OUT) && (!rsp_q || rsp_ready_i);

  // Sequencer next-state.
  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    unique case (state_q)
      ST_IDLE: if (req_acc) state_d = ST_D1;
      ST_D1:   state_d = ST_D2;
      ST_D2:   state_d = ST_A0;
      ST_A0:   state_d = ST_Y;
      ST_Y:    state_d = ST_SQ;
      ST_SQ:   state_d = ST_RAD;
      ST_RAD:  begin state_d = ST_SQRT; sq_start = 1'b1; end
      ST_SQRT: if (sq_done) state_d = ST_A2;
      ST_A2:   state_d = ST_A;
      ST_A:    state_d = ST_QM;
      ST_QM:   begin
        if (aa < DW'(d_q)) state_d = ST_DIV;
        else state_d = ST_FH;
      end
      ST_DIV:  begin
        if (!dv_start && dv_done) state_d = ST_FH;
      end
      ST_FH:   state_d = ST_NV;
      ST_NV:   state_d = ST_OUT;
      ST_OUT:  if (out_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic div_go_q;
  assign dv_start = div_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      vel_q    <= '0;
      rsp_q    <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= (state_q == ST_QM) && (aa < DW'(d_q));
      if (out_fire) begin
        rsp_q <= 1'b1;
        vel_q <= nv_q;
        pos_q <= sup_q ? sat_f(ext_f(x1_q) + ext_f(nv_q))
                       : sat_f(ext_f(x1_q) + ext_f(x2_q));
      end else if (rsp_acc) begin
        rsp_q <= 1'b0;
      end
    end
  end

  // Payload registers, advanced by the sequencer.
  always_ff @(posedge clk_i) begin
    prod_q <= mp;
    fneg_q <= mneg;
    unique case (state_q)
      ST_IDLE: if (req_acc) begin
        sup_q <= req_type_i;
        v_q   <= in_f(target_i);
        x1_q  <= req_type_i ? in_f(pos_in_i) : pos_q;
        x2_q  <= req_type_i ? in_f(vel_in_i) : vel_q;
        r_q   <= sat_f(WW'(speed_q));
        h_q   <= sat_f(WW'(step_q));
      end
      ST_A0: d_q <= (fmul < DW'(1)) ? DW'(1) : fmul;
      ST_Y: begin
        a0_q <= fmul;
        y_q  <= sat_f(ext_f(sat_f(ext_f(x1_q) - ext_f(v_q))) + ext_f(fmul));
      end
      ST_SQ: rad_q <= SW'(prod_q);
      ST_A2: begin
        logic signed [WW-1:0] a1, hdif;
        a1   = (root > (SW/2)'(VMAX[DW-1:0])) ? VMAX : WW'(root);
        hdif = (a1 - ext_f(d_q)) >>> 1;
        a2_q <= sat_f(ext_f(a0_q) + (y_q[DW-1] ? -hdif : (y_q == '0 ? '0 : hdif)));
      end
      ST_A: begin
        if (ay < DW'(d_q)) a_q <= sat_f(ext_f(a0_q) + ext_f(y_q));
        else if (ay == DW'(d_q))
          a_q <= sat_f((ext_f(a0_q) + ext_f(y_q) + ext_f(a2_q)) / 2);
        else a_q <= a2_q;
      end
      ST_FH: begin
        if (aa < DW'(d_q)) begin
          fh_q <= (!a_q[DW-1] && a_q != '0) ? DW'(-quo) : quo;
        end else begin
          fh_q <= (!a_q[DW-1] && a_q != '0) ? -r_q : r_q;
        end
      end
      ST_NV: begin
        logic signed [DW-1:0] n;
        n = sat_f(ext_f(x2_q) + ext_f(fh_q));
        if (!limit_q[31]) begin
          if (ext_f(n) > WW'(limit_q)) n = sat_f(WW'(limit_q));
          if (ext_f(n) < -WW'(limit_q)) n = sat_f(-WW'(limit_q));
        end
        nv_q <= n;
      end
      ST_OUT: if (out_fire) begin
        vel_o_q <= nv_q;
        pos_o_q <= sup_q ? sat_f(ext_f(x1_q) + ext_f(nv_q))
                         : sat_f(ext_f(x1_q) + ext_f(x2_q));
      end
      default: ;
    endcase
  end

  assign rsp_valid_o    = rsp_q;
  assign position_out_o = 32'(pos_o_q);
  assign velocity_out_o = 32'(vel_o_q);

  // ---------------------------------------------------------------- checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req_ready_o) else $error("request taken while busy");
  a_rsp_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> rsp_valid_o) else $error("response missing");
  a_d_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (d_q > 0)) else $error("d not positive");
endmodule
